FILE: rtl/wvm_pkg.sv
`default_nettype none
package wvm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 16;
  localparam int WORLD_BITS = 32;

  // operand widths: world differences need one bit more, plus headroom for negation
  localparam int OPA_W  = WORLD_BITS + 2;
  localparam int OPB_W  = PIXEL_BITS + 2;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int MAG_W  = PROD_W;
  localparam int DVS_W  = WORLD_BITS + 1;
  localparam int DIV_W  = WORLD_BITS;
  localparam int Q_BITS = WORLD_BITS + 1;
  localparam int CMP_W  = DIV_W + Q_BITS;

  // input reg, operand reg, product reg, sum reg, range check, quotient stages, clamp
  localparam int LATENCY = 6 + Q_BITS;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_BOT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_RIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_BOT    = 3'd7;

  localparam logic MODE_W2V = 1'b0;
  localparam logic MODE_V2W = 1'b1;

  localparam logic signed [OPA_W-1:0] ONE_A = OPA_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic valid;
    logic mode;
    logic zero;
  } axis_ctl_t;

  typedef struct packed {
    logic signed [OPA_W-1:0] a1;
    logic signed [OPB_W-1:0] b1;
    logic signed [OPA_W-1:0] a2;
    logic signed [OPB_W-1:0] b2;
    logic signed [DVS_W-1:0] dvs;
  } mac_op_t;

  typedef struct packed {
    logic                         neg;
    logic [MAG_W-1:0]             nmag;
    logic [DIV_W-1:0]             dmag;
  } div_op_t;

  typedef struct packed {
    logic                         valid;
    logic                         sat;
    logic                         zero;
    logic signed [PIXEL_BITS-1:0] pix;
    logic signed [WORLD_BITS-1:0] wld;
  } axis_res_t;

endpackage
`default_nettype wire

FILE: rtl/wvm_mac.sv
`default_nettype none
module wvm_mac
  import wvm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire axis_ctl_t ctl_in,
  input  wire mac_op_t   op_in,
  output axis_ctl_t      ctl_out,
  output div_op_t        div_out
);

  axis_ctl_t                ctl_p;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [DVS_W-1:0]  dvs_p;
  logic signed [PROD_W-1:0] sum;
  logic signed [DVS_W-1:0]  dvs_abs;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.valid <= 1'b0;
    end else begin
      ctl_p.valid <= ctl_in.valid;
    end
    ctl_p.mode <= ctl_in.mode;
    ctl_p.zero <= ctl_in.zero;
    p1         <= PROD_W'(op_in.a1) * PROD_W'(op_in.b1);
    p2         <= PROD_W'(op_in.a2) * PROD_W'(op_in.b2);
    dvs_p      <= op_in.dvs;
  end

  assign sum     = p1 + p2;
  assign dvs_abs = dvs_p[DVS_W-1] ? -dvs_p : dvs_p;

  // sum, split into sign and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_p.valid;
    end
    ctl_out.mode <= ctl_p.mode;
    ctl_out.zero <= ctl_p.zero;
    div_out.neg  <= sum[PROD_W-1] ^ dvs_p[DVS_W-1];
    div_out.nmag <= sum[PROD_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    div_out.dmag <= dvs_abs[DIV_W-1:0];
  end

endmodule
`default_nettype wire

FILE: rtl/wvm_div.sv
`default_nettype none
module wvm_div
  import wvm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire axis_ctl_t ctl_in,
  input  wire div_op_t   op_in,
  output axis_res_t      res
);

  localparam logic [Q_BITS-1:0] PIX_LIM = Q_BITS'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);
  localparam logic [Q_BITS-1:0] WLD_LIM = Q_BITS'((64'd1 << (WORLD_BITS - 1)) - 64'd1);
  localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = PIXEL_BITS'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);
  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = ~PIX_MAX;
  localparam logic signed [WORLD_BITS-1:0] WLD_MAX = WORLD_BITS'((64'd1 << (WORLD_BITS - 1)) - 64'd1);
  localparam logic signed [WORLD_BITS-1:0] WLD_MIN = ~WLD_MAX;

  axis_ctl_t         ctl_s [0:Q_BITS];
  logic              neg_s [0:Q_BITS];
  logic              ovf_s [0:Q_BITS];
  logic [MAG_W-1:0]  rem_s [0:Q_BITS];
  logic [DIV_W-1:0]  dmag_s[0:Q_BITS];
  logic [Q_BITS-1:0] q_s   [0:Q_BITS];

  // quotient above the widest result range: flag it so that the clamp saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0].valid <= 1'b0;
    end else begin
      ctl_s[0].valid <= ctl_in.valid;
    end
    ctl_s[0].mode <= ctl_in.mode;
    ctl_s[0].zero <= ctl_in.zero;
    neg_s[0]      <= op_in.neg;
    ovf_s[0]      <= CMP_W'(op_in.nmag) >= (CMP_W'(op_in.dmag) << Q_BITS);
    rem_s[0]      <= op_in.nmag;
    dmag_s[0]     <= op_in.dmag;
    q_s[0]        <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int J = Q_BITS - 1 - k;
    logic [CMP_W-1:0] sub;
    logic             take;

    assign sub  = CMP_W'(dmag_s[k]) << J;
    assign take = CMP_W'(rem_s[k]) >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1].valid <= 1'b0;
      end else begin
        ctl_s[k+1].valid <= ctl_s[k].valid;
      end
      ctl_s[k+1].mode <= ctl_s[k].mode;
      ctl_s[k+1].zero <= ctl_s[k].zero;
      neg_s[k+1]      <= neg_s[k];
      ovf_s[k+1]      <= ovf_s[k];
      dmag_s[k+1]     <= dmag_s[k];
      rem_s[k+1]      <= take ? (rem_s[k] - sub[MAG_W-1:0]) : rem_s[k];
      q_s[k+1]        <= q_s[k] | (Q_BITS'(take) << J);
    end
  end

  axis_ctl_t                ctl_f;
  logic                     neg_f;
  logic                     ovf_f;
  logic [Q_BITS-1:0]        q_f;
  logic signed [Q_BITS:0]   sv;
  logic                     pix_hi;
  logic                     wld_hi;

  assign ctl_f  = ctl_s[Q_BITS];
  assign neg_f  = neg_s[Q_BITS];
  assign ovf_f  = ovf_s[Q_BITS];
  assign q_f    = q_s[Q_BITS];
  assign sv     = neg_f ? -$signed({1'b0, q_f}) : $signed({1'b0, q_f});
  assign pix_hi = ovf_f || (neg_f ? (q_f > PIX_LIM + Q_BITS'(1)) : (q_f > PIX_LIM));
  assign wld_hi = ovf_f || (neg_f ? (q_f > WLD_LIM + Q_BITS'(1)) : (q_f > WLD_LIM));

  // sign, clamp and route to the field of the mode
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= ctl_f.valid;
    end
    res.zero <= ctl_f.valid && ctl_f.zero;
    if (ctl_f.mode == MODE_W2V) begin
      res.sat <= ctl_f.valid && pix_hi;
      res.pix <= pix_hi ? (neg_f ? PIX_MIN : PIX_MAX) : sv[PIXEL_BITS-1:0];
      res.wld <= '0;
    end else if (!ctl_f.zero) begin
      res.sat <= ctl_f.valid && wld_hi;
      res.pix <= '0;
      res.wld <= wld_hi ? (neg_f ? WLD_MIN : WLD_MAX) : sv[WORLD_BITS-1:0];
    end else begin
      res.sat <= 1'b0;
      res.pix <= '0;
      res.wld <= '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/window_viewport_mapper.sv
// channel | handshake        | fields
// config  | cfg_we           | cfg_index, cfg_data
// input   | start & !busy    | mode, world_x, world_y, pixel_x, pixel_y
// result  | done (one cycle) | out_pixel_x, out_pixel_y, out_world_x, out_world_y,
//         |                  | saturated, divide_error
// one item enters every cycle; busy is held low
// each result passes through the 33 quotient stages of the per-axis
// pipelined restoring divider plus six register stages
// rst is synchronous; it clears the valid bits and loads the default window
// the receiver cannot stall, so done is a one-cycle strobe per item
`default_nettype none
module window_viewport_mapper
  import wvm_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [WORLD_BITS-1:0]         cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic signed [WORLD_BITS-1:0]  world_x,
  input  wire logic signed [WORLD_BITS-1:0]  world_y,
  input  wire logic signed [PIXEL_BITS-1:0]  pixel_x,
  input  wire logic signed [PIXEL_BITS-1:0]  pixel_y,
  output logic                               done,
  output logic signed [PIXEL_BITS-1:0]       out_pixel_x,
  output logic signed [PIXEL_BITS-1:0]       out_pixel_y,
  output logic signed [WORLD_BITS-1:0]       out_world_x,
  output logic signed [WORLD_BITS-1:0]       out_world_y,
  output logic                               saturated,
  output logic                               divide_error
);

  // window and viewport registers
  logic signed [WORLD_BITS-1:0] world_left;
  logic signed [WORLD_BITS-1:0] world_bottom;
  logic signed [WORLD_BITS-1:0] world_right;
  logic signed [WORLD_BITS-1:0] world_top;
  logic signed [PIXEL_BITS-1:0] view_left;
  logic signed [PIXEL_BITS-1:0] view_top_edge;
  logic signed [PIXEL_BITS-1:0] view_right;
  logic signed [PIXEL_BITS-1:0] view_bottom_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_left       <= '0;
      world_bottom     <= '0;
      world_right      <= WORLD_BITS'(ONE_A);
      world_top        <= WORLD_BITS'(ONE_A);
      view_left        <= '0;
      view_top_edge    <= '0;
      view_right       <= PIXEL_BITS'(1);
      view_bottom_edge <= PIXEL_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORLD_LEFT:  world_left       <= cfg_data;
        REG_WORLD_BOT:   world_bottom     <= cfg_data;
        REG_WORLD_RIGHT: world_right      <= cfg_data;
        REG_WORLD_TOP:   world_top        <= cfg_data;
        REG_VIEW_LEFT:   view_left        <= cfg_data[PIXEL_BITS-1:0];
        REG_VIEW_TOP:    view_top_edge    <= cfg_data[PIXEL_BITS-1:0];
        REG_VIEW_RIGHT:  view_right       <= cfg_data[PIXEL_BITS-1:0];
        REG_VIEW_BOT:    view_bottom_edge <= cfg_data[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input register
  logic                         valid_a;
  logic                         mode_a;
  logic signed [WORLD_BITS-1:0] wx_a;
  logic signed [WORLD_BITS-1:0] wy_a;
  logic signed [PIXEL_BITS-1:0] px_a;
  logic signed [PIXEL_BITS-1:0] py_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= start && !busy;
    end
    mode_a <= mode;
    wx_a   <= world_x;
    wy_a   <= world_y;
    px_a   <= pixel_x;
    py_a   <= pixel_y;
  end

  // ranges and offsets; each axis becomes a1*b1 + a2*b2 over a signed divisor
  logic signed [OPA_W-1:0] wxr, wyr, ox, oy, wxr_eff, wyr_eff;
  logic signed [OPB_W-1:0] dx, dy, pxd, pyd;
  mac_op_t                 op_x, op_y;
  axis_ctl_t               ctl_x, ctl_y;

  assign wxr = OPA_W'(world_right) - OPA_W'(world_left);
  assign wyr = OPA_W'(world_top) - OPA_W'(world_bottom);
  assign ox  = OPA_W'(wx_a) - OPA_W'(world_left);
  assign oy  = OPA_W'(wy_a) - OPA_W'(world_bottom);
  assign dx  = OPB_W'(view_right) - OPB_W'(view_left);
  assign dy  = OPB_W'(view_bottom_edge) - OPB_W'(view_top_edge);
  assign pxd = OPB_W'(px_a) - OPB_W'(view_left);
  assign pyd = OPB_W'(py_a) - OPB_W'(view_bottom_edge);

  // a world range that is not positive is not used: divide by one (ONE_A) instead
  assign wxr_eff = (wxr > 0) ? wxr : ONE_A;
  assign wyr_eff = (wyr > 0) ? wyr : ONE_A;

  always_comb begin
    if (mode_a == MODE_W2V) begin
      op_x.a1  = wxr_eff;
      op_x.b1  = OPB_W'(view_left);
      op_x.a2  = ox;
      op_x.b2  = dx;
      op_x.dvs = DVS_W'(wxr_eff);
      op_y.a1  = wyr_eff;
      op_y.b1  = OPB_W'(view_bottom_edge);
      op_y.a2  = oy;
      op_y.b2  = -dy;
      op_y.dvs = DVS_W'(wyr_eff);
    end else begin
      op_x.a1  = OPA_W'(world_left);
      op_x.b1  = dx;
      op_x.a2  = wxr;
      op_x.b2  = pxd;
      op_x.dvs = DVS_W'(dx);
      op_y.a1  = OPA_W'(world_bottom);
      op_y.b1  = dy;
      op_y.a2  = wyr;
      op_y.b2  = -pyd;
      op_y.dvs = DVS_W'(dy);
    end
  end

  // operand register
  mac_op_t   op_x_b, op_y_b;
  axis_ctl_t ctl_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b.valid <= 1'b0;
    end else begin
      ctl_b.valid <= valid_a;
    end
    ctl_b.mode <= mode_a;
    ctl_b.zero <= 1'b0;
    op_x_b     <= op_x;
    op_y_b     <= op_y;
  end

  // a zero viewport range only matters when mapping back to the world
  assign ctl_x = '{valid: ctl_b.valid, mode: ctl_b.mode,
                   zero: (ctl_b.mode == MODE_V2W) && (op_x_b.dvs == '0)};
  assign ctl_y = '{valid: ctl_b.valid, mode: ctl_b.mode,
                   zero: (ctl_b.mode == MODE_V2W) && (op_y_b.dvs == '0)};

  axis_ctl_t mctl_x, mctl_y;
  div_op_t   dop_x, dop_y;
  axis_res_t res_x, res_y;

  wvm_mac u_mac_x (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_x),
    .op_in   (op_x_b),
    .ctl_out (mctl_x),
    .div_out (dop_x)
  );

  wvm_mac u_mac_y (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_y),
    .op_in   (op_y_b),
    .ctl_out (mctl_y),
    .div_out (dop_y)
  );

  wvm_div u_div_x (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (mctl_x),
    .op_in  (dop_x),
    .res    (res_x)
  );

  wvm_div u_div_y (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (mctl_y),
    .op_in  (dop_y),
    .res    (res_y)
  );

  // both axes run in lockstep; the x valid marks the item
  assign done         = res_x.valid;
  assign out_pixel_x  = res_x.pix;
  assign out_pixel_y  = res_y.pix;
  assign out_world_x  = res_x.wld;
  assign out_world_y  = res_y.wld;
  assign saturated    = res_x.sat | res_y.sat;
  assign divide_error = res_x.zero | res_y.zero;

  // a result always stems from an item that start brought in earlier
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  // a zero viewport range only arises when mapping back, so pixels stay zero
  assert property (@(posedge clk) disable iff (rst)
    done && divide_error |-> out_pixel_x == '0 && out_pixel_y == '0)
    else $error("divide error on a world-to-viewport item");

  // pixel and world results never come from the same item
  assert property (@(posedge clk) disable iff (rst)
    done && (out_pixel_x != '0 || out_pixel_y != '0) |->
      out_world_x == '0 && out_world_y == '0 && !divide_error)
    else $error("pixel and world results mixed");

endmodule
`default_nettype wire

FILE: test/window_viewport_mapper_test.sv
`timescale 1ns / 100ps

class map_scoreboard;
  typedef struct {
    logic signed [15:0] pix_x;
    logic signed [15:0] pix_y;
    logic signed [31:0] wld_x;
    logic signed [31:0] wld_y;
    logic               sat;
    logic               derr;
  } mapped_point_t;

  mapped_point_t pending[$];
  logic [31:0]   window_regs[8];
  int            mismatches;
  int            checked;

  function new();
    mismatches = 0;
    checked = 0;
    window_regs[0] = 0;
    window_regs[1] = 0;
    window_regs[2] = 32'h0001_0000;
    window_regs[3] = 32'h0001_0000;
    window_regs[4] = 0;
    window_regs[5] = 0;
    window_regs[6] = 1;
    window_regs[7] = 1;
  endfunction

  function void set_reg(int idx, logic [31:0] val);
    if (idx < 4) window_regs[idx] = val;
    else window_regs[idx] = {16'h0, val[15:0]};
  endfunction

  function longint wreg(int idx);
    return longint'(signed'(window_regs[idx]));
  endfunction

  function longint vreg(int idx);
    return longint'(signed'(window_regs[idx][15:0]));
  endfunction

  function longint clamp_to(longint v, int bits, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // work out the mapped point for one accepted item
  function void note_point(logic m, logic [31:0] wx, logic [31:0] wy,
                           logic [15:0] px, logic [15:0] py);
    longint wl, wb, wr, wt, vl, vt, vr, vb, wxr, wyr, dx, dy, one, ox, oy, q;
    mapped_point_t e;
    wl = wreg(0); wb = wreg(1); wr = wreg(2); wt = wreg(3);
    vl = vreg(4); vt = vreg(5); vr = vreg(6); vb = vreg(7);
    wxr = wr - wl;
    wyr = wt - wb;
    dx = vr - vl;
    dy = vb - vt;
    one = longint'(1) <<< 16;
    e.pix_x = '0; e.pix_y = '0; e.wld_x = '0; e.wld_y = '0;
    e.sat = 1'b0; e.derr = 1'b0;
    if (m == wvm_pkg::MODE_W2V) begin
      ox = longint'(signed'(wx)) - wl;
      oy = longint'(signed'(wy)) - wb;
      if (wxr > 0) q = (vl * wxr + ox * dx) / wxr;
      else q = (vl * one + ox * dx) / one;
      e.pix_x = 16'(clamp_to(q, 16, e.sat));
      if (wyr > 0) q = (vb * wyr - oy * dy) / wyr;
      else q = (vb * one - oy * dy) / one;
      e.pix_y = 16'(clamp_to(q, 16, e.sat));
    end else begin
      if (dx != 0)
        e.wld_x = 32'(clamp_to((wl * dx + (longint'(signed'(px)) - vl) * wxr) / dx, 32,
                               e.sat));
      else e.derr = 1'b1;
      if (dy != 0)
        e.wld_y = 32'(clamp_to((wb * dy - (longint'(signed'(py)) - vb) * wyr) / dy, 32,
                               e.sat));
      else e.derr = 1'b1;
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [31:0] wx, logic signed [31:0] wy,
                             logic sat, logic derr);
    mapped_point_t e;
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected", $time);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (px !== e.pix_x) begin
      mismatches++;
      $display("%0t: out_pixel_x expected %0d got %0d", $time, e.pix_x, px);
    end
    if (py !== e.pix_y) begin
      mismatches++;
      $display("%0t: out_pixel_y expected %0d got %0d", $time, e.pix_y, py);
    end
    if (wx !== e.wld_x) begin
      mismatches++;
      $display("%0t: out_world_x expected %0d got %0d", $time, e.wld_x, wx);
    end
    if (wy !== e.wld_y) begin
      mismatches++;
      $display("%0t: out_world_y expected %0d got %0d", $time, e.wld_y, wy);
    end
    if (sat !== e.sat) begin
      mismatches++;
      $display("%0t: saturated expected %0b got %0b", $time, e.sat, sat);
    end
    if (derr !== e.derr) begin
      mismatches++;
      $display("%0t: divide_error expected %0b got %0b", $time, e.derr, derr);
    end
  endfunction
endclass

module window_viewport_mapper_test;
  import wvm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic signed [31:0] world_x = '0;
  logic signed [31:0] world_y = '0;
  logic signed [15:0] pixel_x = '0;
  logic signed [15:0] pixel_y = '0;
  logic        done;
  logic signed [15:0] out_pixel_x;
  logic signed [15:0] out_pixel_y;
  logic signed [31:0] out_world_x;
  logic signed [31:0] out_world_y;
  logic        saturated;
  logic        divide_error;

  map_scoreboard sb = new();

  int idle_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int phases_done = 0;

  window_viewport_mapper uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .mode(mode), .world_x(world_x), .world_y(world_y),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done), .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y), .out_world_x(out_world_x), .out_world_y(out_world_y),
    .saturated(saturated), .divide_error(divide_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // results are strobed for one cycle, check them at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(out_pixel_x, out_pixel_y, out_world_x, out_world_y,
                      saturated, divide_error);
  end

  // watchdog: cycles where neither an item nor a result moves
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // one item; start stays high if the next item follows back to back
  task automatic send_point(logic m, logic [31:0] wx, logic [31:0] wy,
                            logic [15:0] px, logic [15:0] py);
    start   <= 1'b1;
    mode    <= m;
    world_x <= wx;
    world_y <= wy;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (busy);
    sb.note_point(m, wx, wy, px, py);
    items_sent++;
  endtask

  // sender bursts with random gaps in between
  task automatic sender_gap();
    int g;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    if ($urandom_range(0, 3) == 0) return;
    g = $urandom_range(1, 8);
    start <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  // hold off until every pending mapped point has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_window(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(i, vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // biased toward field extremes now and then
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // a point inside the world window, if it has a positive span
  function automatic logic [31:0] inside_world(int lo_idx, int hi_idx);
    longint lo;
    longint span;
    lo = sb.wreg(lo_idx);
    span = sb.wreg(hi_idx) - lo;
    if (span <= 0) return $urandom;
    return 32'(lo + (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff_ffff) % (span + 1));
  endfunction

  function automatic logic [15:0] inside_view(int a_idx, int b_idx);
    longint a;
    longint b;
    a = sb.vreg(a_idx);
    b = sb.vreg(b_idx);
    if (a > b) begin
      a = sb.vreg(b_idx);
      b = sb.vreg(a_idx);
    end
    return 16'(a + longint'($urandom) % (b - a + 1));
  endfunction

  // register sets for each phase; phase 0 keeps the reset window
  function automatic void window_for_phase(int p, output logic [31:0] v[8]);
    case (p)
      1: v = '{32'hfff6_0000, 32'hfff6_0000, 32'h000a_0000, 32'h000a_0000,
               32'd0, 32'd0, 32'd639, 32'd479};
      // widest window and viewport
      2: v = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000, 32'h8000, 32'h7fff, 32'h7fff};
      // degenerate viewport: both device spans zero
      3: v = '{32'hffff_0000, 32'h0000_8000, 32'h0003_0000, 32'h0002_0000,
               32'd100, 32'd200, 32'd100, 32'd200};
      // world spans not positive: reversed x, empty y
      4: v = '{32'h0005_0000, 32'h0001_0000, 32'hfffb_0000, 32'h0001_0000,
               32'd10, 32'd20, 32'd300, 32'd220};
      // reversed viewport and tiny window, drives clamping
      5: v = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
               32'h7fff, 32'h7fff, 32'h8000, 32'h8000};
      default: for (int i = 0; i < 8; i++) v[i] = (i < 4) ? pick32() : {16'h0, pick16()};
    endcase
  endfunction

  initial begin
    logic [31:0] regs[8];
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        window_for_phase(p, regs);
        load_window(regs);
      end
      // directed corners of the input fields, both directions
      if (p < 6) begin
        send_point(MODE_W2V, 32'h7fff_ffff, 32'h8000_0000, 16'h0, 16'h0);
        send_point(MODE_W2V, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'hffff);
        send_point(MODE_V2W, 32'h0, 32'h0, 16'h7fff, 16'h8000);
        send_point(MODE_V2W, 32'hffff_ffff, 32'hffff_ffff, 16'h8000, 16'h7fff);
      end
      n = (p == PHASES - 1) ? 100 : 120;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 2) != 0) begin
          // well-formed: inside the window or viewport
          if ($urandom_range(0, 1) == 0)
            send_point(MODE_W2V, inside_world(0, 2), inside_world(1, 3), pick16(), pick16());
          else
            send_point(MODE_V2W, pick32(), pick32(), inside_view(4, 6), inside_view(5, 7));
        end else begin
          send_point(1'($urandom_range(0, 1)), pick32(), pick32(), pick16(), pick16());
        end
        if (k == n / 2 && p % 2 == 1) drain();
        else sender_gap();
      end
      drain();
      phases_done++;
    end

    $display("mapped %0d points over %0d window settings, %0d results checked",
             items_sent, phases_done, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d points never returned", sb.mismatches,
               sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
